/* rtl/sac_pkg.sv */
// ----------------------------------------------------------------------------
// sac_pkg
// Shared types, constants and arithmetic helpers of the supply converter
// conditioner.
// ----------------------------------------------------------------------------
`default_nettype none

package sac_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int MED_DEPTH  = 3;
	localparam int MED_POS_W  = $clog2(MED_DEPTH);
	localparam int AVG_LOG2   = 3;
	localparam int AVG_DEPTH  = 1 << AVG_LOG2;
	localparam int SUM_W      = SAMPLE_W + AVG_LOG2;

	localparam int IN_DATA_W  = 112;
	localparam int OUT_DATA_W = 88;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef logic [SAMPLE_W-1:0] sample_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DIGITAL_FILTER = 3'd0,
		REG_EXT_AMP_INT    = 3'd1,
		REG_EXT_FREQ_INT   = 3'd2,
		REG_CENTER_FREQ    = 3'd3,
		REG_FREQ_SWING     = 3'd4
	} cfg_reg_t;

	localparam logic [15:0] CENTER_RESET = 16'd19950;
	localparam logic [11:0] SWING_RESET  = 12'd500;

	localparam logic [15:0] FULL_SCALE   = 16'hFFFF;
	localparam logic [15:0] BAR_TOP      = 16'd63897;  // full scale less half a volt
	localparam logic [4:0]  BAR_GAIN     = 5'd20;
	localparam logic [4:0]  BAR_OFFSET   = 5'd3;
	localparam logic [4:0]  BAR_MAX      = 5'd12;
	localparam logic [9:0]  AMP_GAIN     = 10'd1000;
	localparam logic [10:0] PWR_GAIN     = 11'd1333;
	localparam logic [9:0]  REF_GAIN     = 10'd1000;
	localparam logic [9:0]  REF_FULL     = 10'd1000;
	localparam logic [7:0]  XAMP_GAIN    = 8'd201;
	localparam logic [6:0]  XAMP_MAX     = 7'd100;
	localparam logic [6:0]  XAMP_MIN     = 7'd10;
	localparam logic [9:0]  XFREQ_GAIN   = 10'd1023;
	localparam logic [15:0] HZ_MAX       = 16'hFFFF;

	function automatic sample_t median3(input sample_t a, input sample_t b, input sample_t c);
		sample_t lo;
		sample_t hi;
		sample_t mid;
		lo  = (a > b) ? b : a;
		hi  = (a > b) ? a : b;
		mid = (hi > c) ? c : hi;
		return (lo > mid) ? lo : mid;
	endfunction

	// x / 65535 for quotients below 65535: high half plus one correction step
	function automatic logic [16:0] div_full_scale(input logic [31:0] x);
		logic [16:0] q0;
		logic [16:0] rem;
		q0  = {1'b0, x[31:16]};
		rem = {1'b0, x[15:0]} + q0;
		return (rem >= {1'b0, FULL_SCALE}) ? q0 + 17'd1 : q0;
	endfunction

	function automatic logic [3:0] bar_clamp(input logic neg, input logic [4:0] q);
		logic [4:0] s;
		s = q - BAR_OFFSET;
		if (neg || q < BAR_OFFSET)
			return 4'd0;
		else if (s > BAR_MAX)
			return BAR_MAX[3:0];
		else
			return s[3:0];
	endfunction

endpackage

`default_nettype wire

/* rtl/supply_adc_conditioner.sv */
// ----------------------------------------------------------------------------
// supply_adc_conditioner
// Conditions one scan of seven supply converter channels per item: median and
// moving-average filtering, scaling to display units, bargraph steps,
// frequency readout and reference check.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+---------------------------
//  s_axis   | in        | tvalid / tready        | tdata 112b scan, tuser mode
//  m_axis   | out       | tvalid / tready        | tdata 88b levels, tuser run
//  cfg      | in        | cfg_we, no wait        | cfg_index 3b, cfg_data 16b
//
// One item per cycle while m_axis does not stall; after the input register
// each item passes the filter stage, the multiply stage and the
// scale/result register.
// Each stage loads when empty or when the stage after it moves, so stalls
// from m_axis back up stage by stage and bubbles are squeezed out.
// Reset clears filter windows, average rings and sums, the latched reference
// level and returns the registers to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module supply_adc_conditioner (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	// freq, amp, power, memory, ext_freq, ext_amp, ref (16b each, low first)
	input  wire logic [sac_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// powered_up
	input  wire logic                             s_axis_tuser,
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	// amp_level 10, power_level 11, memory_bar 4, actual_bar 4, frequency_hz 16,
	// ext_amp 16, ext_freq_offset 16, ten_volt_ref 10, zero pad 1
	output logic [sac_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
	// run_valid
	output logic                                  m_axis_tuser,
	input  wire logic                             cfg_we,
	input  wire logic [sac_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [sac_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import sac_pkg::*;

	// configuration
	logic        filter_q;
	logic        ext_amp_int_q;
	logic        ext_freq_int_q;
	logic [15:0] center_q;
	logic [11:0] swing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_q       <= 1'b0;
			ext_amp_int_q  <= 1'b0;
			ext_freq_int_q <= 1'b0;
			center_q       <= CENTER_RESET;
			swing_q        <= SWING_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DIGITAL_FILTER: filter_q       <= cfg_data[0];
				REG_EXT_AMP_INT:    ext_amp_int_q  <= cfg_data[0];
				REG_EXT_FREQ_INT:   ext_freq_int_q <= cfg_data[0];
				REG_CENTER_FREQ:    center_q       <= cfg_data;
				REG_FREQ_SWING:     swing_q        <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	// pipeline flow control
	logic valid_s1, valid_s2, valid_s3, out_valid_q;
	logic ld1, ld2, ld3, ld_out;

	assign ld_out        = !out_valid_q || m_axis_tready;
	assign ld3           = !valid_s3 || ld_out;
	assign ld2           = !valid_s2 || ld3;
	assign ld1           = !valid_s1 || ld2;
	assign s_axis_tready = ld1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ld1)    valid_s1    <= s_axis_tvalid;
			if (ld2)    valid_s2    <= valid_s1;
			if (ld3)    valid_s3    <= valid_s2;
			if (ld_out) out_valid_q <= valid_s3;
		end
	end

	// stage 1: input register
	sample_t freq_s1, amp_s1, pwr_s1, mem_s1, xfreq_s1, xamp_s1, ref_s1;
	logic    run_s1;

	always_ff @(posedge clk) begin
		if (ld1 && s_axis_tvalid) begin
			freq_s1  <= s_axis_tdata[15:0];
			amp_s1   <= s_axis_tdata[31:16];
			pwr_s1   <= s_axis_tdata[47:32];
			mem_s1   <= s_axis_tdata[63:48];
			xfreq_s1 <= s_axis_tdata[79:64];
			xamp_s1  <= s_axis_tdata[95:80];
			ref_s1   <= s_axis_tdata[111:96];
			run_s1   <= s_axis_tuser;
		end
	end

	// filters, updated as the item leaves stage 1
	logic    adv1, push_med_run, push_avg_run;
	sample_t mem_med, freq_med, amp_med, pwr_med, amp_avg, pwr_avg;

	assign adv1         = valid_s1 && ld2;
	assign push_med_run = adv1 && run_s1 && !filter_q;
	assign push_avg_run = adv1 && run_s1 && filter_q;

	sac_median_window u_mem_med  (.clk, .arst_n, .push(adv1),         .din(mem_s1),
		.median(mem_med));
	sac_median_window u_freq_med (.clk, .arst_n, .push(adv1),         .din(freq_s1),
		.median(freq_med));
	sac_median_window u_amp_med  (.clk, .arst_n, .push(push_med_run), .din(amp_s1),
		.median(amp_med));
	sac_median_window u_pwr_med  (.clk, .arst_n, .push(push_med_run), .din(pwr_s1),
		.median(pwr_med));
	sac_moving_avg    u_amp_avg  (.clk, .arst_n, .push(push_avg_run), .din(amp_s1),
		.mean(amp_avg));
	sac_moving_avg    u_pwr_avg  (.clk, .arst_n, .push(push_avg_run), .din(pwr_s1),
		.mean(pwr_avg));

	// stage 2: filtered values
	sample_t amp_s2, pwr_s2, mem_s2, freq_s2, xfreq_s2, xamp_s2, ref_s2;
	logic    run_s2;

	always_ff @(posedge clk) begin
		if (ld2 && valid_s1) begin
			amp_s2   <= filter_q ? amp_avg : amp_med;
			pwr_s2   <= filter_q ? pwr_avg : pwr_med;
			mem_s2   <= mem_med;
			freq_s2  <= freq_med;
			xfreq_s2 <= xfreq_s1;
			xamp_s2  <= xamp_s1;
			ref_s2   <= ref_s1;
			run_s2   <= run_s1;
		end
	end

	// stage 3: products
	logic [25:0] amp_prod_s3;
	logic [26:0] pwr_prod_s3;
	logic [27:0] fsw_prod_s3;
	logic [20:0] mbar_prod_s3, abar_prod_s3;
	logic        mbar_neg_s3, abar_neg_s3;
	logic [23:0] xamp_prod_s3;
	logic [25:0] xfreq_prod_s3;
	logic [24:0] ref_prod_s3;
	logic        ref_ovr_s3;
	sample_t     xamp_s3, xfreq_s3;
	logic        run_s3;

	always_ff @(posedge clk) begin
		if (ld3 && valid_s2) begin
			amp_prod_s3   <= 26'(amp_s2) * 26'(AMP_GAIN);
			pwr_prod_s3   <= 27'(pwr_s2) * 27'(PWR_GAIN);
			fsw_prod_s3   <= 28'(freq_s2) * 28'(swing_q);
			mbar_neg_s3   <= mem_s2 > BAR_TOP;
			mbar_prod_s3  <= 21'(BAR_TOP - mem_s2) * 21'(BAR_GAIN);
			abar_neg_s3   <= freq_s2 > BAR_TOP;
			abar_prod_s3  <= 21'(BAR_TOP - freq_s2) * 21'(BAR_GAIN);
			xamp_prod_s3  <= 24'(xamp_s2) * 24'(XAMP_GAIN);
			xfreq_prod_s3 <= 26'(xfreq_s2) * 26'(XFREQ_GAIN);
			ref_prod_s3   <= 25'(ref_s2[14:0]) * 25'(REF_GAIN);
			ref_ovr_s3    <= ref_s2[15];
			xamp_s3       <= xamp_s2;
			xfreq_s3      <= xfreq_s2;
			run_s3        <= run_s2;
		end
	end

	// scale, clamp and frequency readout
	logic        adv3;
	logic [16:0] amp_q, pwr_q, mbar_q, abar_q, fsw_q, xamp_q, xfreq_q, ref_q;
	logic [17:0] hz_raw;
	sample_t     hz_sat, hz_avg, hz_val, ext_amp_val, ext_freq_val;
	logic [6:0]  xamp_pct;
	logic [9:0]  ref_level, tref, last_ref_q;
	logic [3:0]  mbar, abar;

	assign adv3 = valid_s3 && ld_out;

	always_comb begin
		amp_q   = div_full_scale(32'(amp_prod_s3));
		pwr_q   = div_full_scale(32'(pwr_prod_s3));
		mbar_q  = div_full_scale(32'(mbar_prod_s3));
		abar_q  = div_full_scale(32'(abar_prod_s3));
		fsw_q   = div_full_scale(32'({fsw_prod_s3, 1'b0}));
		// halve first: floor(x / 131070) = floor(floor(x / 2) / 65535)
		xamp_q  = div_full_scale(32'(xamp_prod_s3[23:1]));
		xfreq_q = div_full_scale(32'(xfreq_prod_s3));
		ref_q   = div_full_scale(32'(ref_prod_s3));

		mbar = bar_clamp(mbar_neg_s3, mbar_q[4:0]);
		abar = bar_clamp(abar_neg_s3, abar_q[4:0]);

		hz_raw = 18'(center_q) + 18'(swing_q) - 18'(fsw_q[12:0]);
		if (hz_raw[17])
			hz_sat = '0;
		else if (hz_raw[16])
			hz_sat = HZ_MAX;
		else
			hz_sat = hz_raw[15:0];

		if (xamp_q[6:0] > XAMP_MAX)
			xamp_pct = XAMP_MAX;
		else if (xamp_q[6:0] < XAMP_MIN)
			xamp_pct = XAMP_MIN;
		else
			xamp_pct = xamp_q[6:0];
		ext_amp_val  = ext_amp_int_q ? xamp_s3 : 16'(xamp_pct);
		ext_freq_val = ext_freq_int_q ? xfreq_s3 : 16'(xfreq_q[9:0]);

		ref_level = ref_ovr_s3 ? REF_FULL : ref_q[9:0];
		tref      = run_s3 ? last_ref_q : ref_level;
	end

	sac_moving_avg u_hz_avg (.clk, .arst_n, .push(adv3 && run_s3 && filter_q), .din(hz_sat),
		.mean(hz_avg));

	assign hz_val = filter_q ? hz_avg : hz_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_ref_q <= '0;
		end else if (adv3 && !run_s3) begin
			last_ref_q <= ref_level;
		end
	end

	// result register
	logic [OUT_DATA_W-1:0] out_data_q;
	logic                  out_run_q;

	always_ff @(posedge clk) begin
		if (adv3) begin
			out_run_q  <= run_s3;
			out_data_q <= {1'b0, tref, ext_freq_val, ext_amp_val,
				run_s3 ? hz_val      : 16'd0,
				run_s3 ? abar        : 4'd0,
				run_s3 ? mbar        : 4'd0,
				run_s3 ? pwr_q[10:0] : 11'd0,
				run_s3 ? amp_q[9:0]  : 10'd0};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_run_q;

endmodule

`default_nettype wire

/* rtl/sac_median_window.sv */
// ----------------------------------------------------------------------------
// sac_median_window
// Three-entry sample window with its write position; gives the median of the
// window as it stands after the current push.
// ----------------------------------------------------------------------------
`default_nettype none

module sac_median_window (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire sac_pkg::sample_t din,
	output sac_pkg::sample_t      median
);
	import sac_pkg::*;

	sample_t              win_q [MED_DEPTH];
	sample_t              win_d [MED_DEPTH];
	logic [MED_POS_W-1:0] pos_q;

	always_comb begin
		for (int i = 0; i < MED_DEPTH; i++) begin
			win_d[i] = (push && pos_q == MED_POS_W'(i)) ? din : win_q[i];
		end
	end

	assign median = median3(win_d[0], win_d[1], win_d[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MED_DEPTH; i++) begin
				win_q[i] <= '0;
			end
			pos_q <= '0;
		end else if (push) begin
			win_q <= win_d;
			pos_q <= (pos_q == MED_POS_W'(MED_DEPTH - 1)) ? '0 : pos_q + 1'b1;
		end
	end

endmodule

`default_nettype wire

/* rtl/sac_moving_avg.sv */
// ----------------------------------------------------------------------------
// sac_moving_avg
// Ring of the last AVG_DEPTH samples with a running sum; gives the mean
// including the sample being pushed.
// ----------------------------------------------------------------------------
`default_nettype none

module sac_moving_avg (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire sac_pkg::sample_t din,
	output sac_pkg::sample_t      mean
);
	import sac_pkg::*;

	sample_t             ring_q [AVG_DEPTH];
	logic [AVG_LOG2-1:0] pos_q;
	logic [SUM_W-1:0]    sum_q;
	logic [SUM_W-1:0]    sum_d;

	// drop the oldest entry, add the new one
	assign sum_d = sum_q - SUM_W'(ring_q[pos_q]) + SUM_W'(din);
	assign mean  = sum_d[SUM_W-1:AVG_LOG2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AVG_DEPTH; i++) begin
				ring_q[i] <= '0;
			end
			pos_q <= '0;
			sum_q <= '0;
		end else if (push) begin
			ring_q[pos_q] <= din;
			pos_q         <= pos_q + 1'b1;
			sum_q         <= sum_d;
		end
	end

endmodule

`default_nettype wire

/* rtl/sac_checker.sv */
// ----------------------------------------------------------------------------
// sac_checker
// Port-level checks of the supply converter conditioner, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module sac_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             s_axis_tready,
	input wire logic                             m_axis_tvalid,
	input wire logic                             m_axis_tready,
	input wire logic [sac_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	input wire logic                             m_axis_tuser
);
	import sac_pkg::*;

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("stalled result changed");

	// the input side only stalls when a result waits at the output
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled with output free");

	// reference check mode clears all running levels
	a_ref_mode_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[44:0] == 45'd0)
		else $error("running levels set in reference mode");

	// display ranges
	a_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[9:0] <= 10'd1000 && m_axis_tdata[20:10] <= 11'd1333
			&& m_axis_tdata[24:21] <= 4'd12 && m_axis_tdata[28:25] <= 4'd12
			&& m_axis_tdata[86:77] <= 10'd1000 && !m_axis_tdata[87])
		else $error("result field out of range");

endmodule

bind supply_adc_conditioner sac_checker u_sac_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// supply_adc_conditioner testbench
// Streams converter scans into the conditioner and compares every result,
// field by field, against a cycle-free predictor of the filters and scaling
// or typed table values. A short table of directed scans and register
// writes comes first, then random phases that each pick a register setting
// and a pattern of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import sac_pkg::*;

	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 190;
	localparam int HOLD_CYCLES = 80;

	localparam logic [CFG_IDX_W-1:0] REG_FIRST_SPARE = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_LAST_SPARE  = 3'd7;

	// median window slots and average ring slots
	localparam int MED_AMP  = 0;
	localparam int MED_PWR  = 1;
	localparam int MED_MEM  = 2;
	localparam int MED_FREQ = 3;
	localparam int AVG_AMP  = 0;
	localparam int AVG_PWR  = 1;
	localparam int AVG_FREQ = 2;

	typedef enum logic [1:0] {
		FLOW_FREE,
		FLOW_SENDER_IDLE,
		FLOW_RECEIVER_STALL,
		FLOW_BOTH_IDLE
	} flow_t;

	typedef enum logic {ROW_SCAN, ROW_WRITE} row_kind_t;

	typedef struct packed {
		logic [15:0] freq;
		logic [15:0] amp;
		logic [15:0] power;
		logic [15:0] memory;
		logic [15:0] ext_freq;
		logic [15:0] ext_amp;
		logic [15:0] ref_v;
	} scan_t;

	// run_valid on top, then tdata from bit 87 down to bit 0
	typedef struct packed {
		logic        run;
		logic        spare;
		logic [9:0]  ten_volt_ref;
		logic [15:0] ext_freq_offset;
		logic [15:0] ext_amp;
		logic [15:0] frequency_hz;
		logic [3:0]  actual_bar;
		logic [3:0]  memory_bar;
		logic [10:0] power_level;
		logic [9:0]  amp_level;
	} level_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [2:0]  reg_index;
		logic [15:0] reg_value;
		logic        powered;
		scan_t       scan;
		logic        typed;
		logic [15:0] want_ext_amp;
		logic [15:0] want_ext_freq;
		logic [9:0]  want_ref;
	} row_t;

	// scan fields: freq, amp, power, memory, ext_freq, ext_amp, ref
	// register index is ignored on scan rows
	localparam row_t PLAN [25] = '{
		'{ROW_SCAN, REG_LAST_SPARE, 16'h0000, 1'b0,
			'{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
			1'b1, 16'd10, 16'd0, 10'd0},
		'{ROW_SCAN, REG_LAST_SPARE, 16'h0000, 1'b0,
			'{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h8000},
			1'b1, 16'd100, 16'd1023, 10'd1000},
		'{ROW_SCAN, REG_LAST_SPARE, 16'h0000, 1'b0,
			'{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h8000, 16'h7FFF},
			1'b1, 16'd50, 16'd511, 10'd499},
		'{ROW_SCAN, REG_LAST_SPARE, 16'h0000, 1'b0,
			'{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0CCC, 16'hFFFF},
			1'b1, 16'd10, 16'd0, 10'd1000},
		'{ROW_SCAN, REG_LAST_SPARE, 16'h0000, 1'b1,
			'{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
			1'b0, 16'd0, 16'd0, 10'd0},
		'{ROW_SCAN, REG_LAST_SPARE, 16'h0000, 1'b1,
			'{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
			1'b0, 16'd0, 16'd0, 10'd0},
		'{ROW_SCAN, REG_LAST_SPARE, 16'h0000, 1'b1,
			'{16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000},
			1'b0, 16'd0, 16'd0, 10'd0},
		'{ROW_SCAN, REG_LAST_SPARE, 16'h0000, 1'b1,
			'{16'hFFFF, 16'h1234, 16'h4321, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000},
			1'b0, 16'd0, 16'd0, 10'd0},
		'{ROW_SCAN, REG_LAST_SPARE, 16'h0000, 1'b1,
			'{16'h7FFF, 16'h0000, 16'hFFFF, 16'h8000, 16'h0000, 16'h0000, 16'h0000},
			1'b0, 16'd0, 16'd0, 10'd0},
		'{ROW_SCAN, REG_LAST_SPARE, 16'h0000, 1'b0,
			'{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 16'h7FFF, 16'h1234},
			1'b1, 16'd50, 16'd511, 10'd71},
		'{ROW_SCAN, REG_LAST_SPARE, 16'h0000, 1'b1,
			'{16'h4000, 16'h8000, 16'h8000, 16'hC000, 16'h0000, 16'h0000, 16'h0000},
			1'b0, 16'd0, 16'd0, 10'd0},
		'{ROW_WRITE, REG_EXT_AMP_INT, 16'h0001, 1'b0, '0, 1'b0, 16'd0, 16'd0, 10'd0},
		'{ROW_WRITE, REG_EXT_FREQ_INT, 16'h0001, 1'b0, '0, 1'b0, 16'd0, 16'd0, 10'd0},
		'{ROW_SCAN, REG_LAST_SPARE, 16'h0000, 1'b1,
			'{16'h0001, 16'h0000, 16'h0000, 16'h0002, 16'hFFFF, 16'hFFFF, 16'h0000},
			1'b0, 16'd0, 16'd0, 10'd0},
		'{ROW_WRITE, REG_DIGITAL_FILTER, 16'h0001, 1'b0, '0, 1'b0, 16'd0, 16'd0, 10'd0},
		'{ROW_SCAN, REG_LAST_SPARE, 16'h0000, 1'b1,
			'{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
			1'b0, 16'd0, 16'd0, 10'd0},
		'{ROW_SCAN, REG_LAST_SPARE, 16'h0000, 1'b1,
			'{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
			1'b0, 16'd0, 16'd0, 10'd0},
		'{ROW_SCAN, REG_LAST_SPARE, 16'h0000, 1'b1,
			'{16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000},
			1'b0, 16'd0, 16'd0, 10'd0},
		'{ROW_WRITE, REG_CENTER_FREQ, 16'h0000, 1'b0, '0, 1'b0, 16'd0, 16'd0, 10'd0},
		'{ROW_WRITE, REG_FREQ_SWING, 16'hFFFF, 1'b0, '0, 1'b0, 16'd0, 16'd0, 10'd0},
		'{ROW_SCAN, REG_LAST_SPARE, 16'h0000, 1'b1,
			'{16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
			1'b0, 16'd0, 16'd0, 10'd0},
		'{ROW_WRITE, REG_CENTER_FREQ, 16'hFFFF, 1'b0, '0, 1'b0, 16'd0, 16'd0, 10'd0},
		'{ROW_SCAN, REG_LAST_SPARE, 16'h0000, 1'b1,
			'{16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000},
			1'b0, 16'd0, 16'd0, 10'd0},
		'{ROW_WRITE, REG_LAST_SPARE, 16'hFFFF, 1'b0, '0, 1'b0, 16'd0, 16'd0, 10'd0},
		'{ROW_SCAN, REG_LAST_SPARE, 16'h0000, 1'b1,
			'{16'h0000, 16'h2000, 16'hE000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
			1'b0, 16'd0, 16'd0, 10'd0}
	};

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
	logic                  s_axis_tuser  = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tuser;
	logic                  cfg_we        = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index     = '0;
	logic [CFG_DATA_W-1:0] cfg_data      = '0;

	flow_t  flow        = FLOW_FREE;
	int     hold_asked  = 0;
	int     hold_served = 0;
	int     hold_left   = 0;
	int     mismatches  = 0;
	level_t due_levels[$];

	// predictor copy of the registers and filter state
	logic        filter_on;
	logic        amp_raw;
	logic        freq_raw;
	logic [15:0] center_hz;
	logic [11:0] swing_hz;
	logic [15:0] med_win [4][MED_DEPTH];
	int          med_pos [4];
	logic [15:0] avg_ring [3][AVG_DEPTH];
	int          avg_pos [3];
	int          avg_sum [3];
	logic [9:0]  ref_latched;

	supply_adc_conditioner DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic void clear_model();
		filter_on   = 1'b0;
		amp_raw     = 1'b0;
		freq_raw    = 1'b0;
		center_hz   = 16'd19950;
		swing_hz    = 12'd500;
		ref_latched = '0;
		for (int i = 0; i < 4; i++) begin
			med_pos[i] = 0;
			for (int j = 0; j < MED_DEPTH; j++)
				med_win[i][j] = '0;
		end
		for (int i = 0; i < 3; i++) begin
			avg_pos[i] = 0;
			avg_sum[i] = 0;
			for (int j = 0; j < AVG_DEPTH; j++)
				avg_ring[i][j] = '0;
		end
	endfunction

	function automatic void set_reg(logic [2:0] index, logic [15:0] value);
		case (index)
			REG_DIGITAL_FILTER: filter_on = value[0];
			REG_EXT_AMP_INT: amp_raw = value[0];
			REG_EXT_FREQ_INT: freq_raw = value[0];
			REG_CENTER_FREQ: center_hz = value;
			REG_FREQ_SWING: swing_hz = value[11:0];
			default: ;
		endcase
	endfunction

	function automatic void push_median(int slot, logic [15:0] v);
		med_win[slot][med_pos[slot]] = v;
		med_pos[slot] = (med_pos[slot] + 1) % MED_DEPTH;
	endfunction

	function automatic int window_median(int slot);
		int a;
		int b;
		int c;
		a = med_win[slot][0];
		b = med_win[slot][1];
		c = med_win[slot][2];
		if ((a >= b && a <= c) || (a <= b && a >= c))
			return a;
		if ((b >= a && b <= c) || (b <= a && b >= c))
			return b;
		return c;
	endfunction

	function automatic int push_average(int slot, logic [15:0] v);
		avg_sum[slot] = avg_sum[slot] - int'(avg_ring[slot][avg_pos[slot]]) + int'(v);
		avg_ring[slot][avg_pos[slot]] = v;
		avg_pos[slot] = (avg_pos[slot] + 1) % AVG_DEPTH;
		return avg_sum[slot] / AVG_DEPTH;
	endfunction

	// signed, truncating toward zero, then clamp to the 13 bargraph steps
	function automatic logic [3:0] bar_step(int m);
		int x;
		int s;
		x = 65535 - m - 1638;
		s = (x * 20) / 65535 - 3;
		if (s < 0)
			s = 0;
		if (s > 12)
			s = 12;
		return 4'(s);
	endfunction

	function automatic level_t condition_scan(scan_t s, logic powered);
		level_t r;
		int     a;
		int     p;
		int     f;
		int     h;
		int     xa;
		int     xf;
		int     rv;
		int     c;
		int     w;
		r = '0;
		push_median(MED_MEM, s.memory);
		push_median(MED_FREQ, s.freq);
		xa = s.ext_amp;
		if (!amp_raw) begin
			xa = (xa * 201) / 131070;
			if (xa > 100)
				xa = 100;
			if (xa < 10)
				xa = 10;
		end
		xf = s.ext_freq;
		if (!freq_raw)
			xf = (xf * 1023) / 65535;
		if (!powered) begin
			rv = s.ref_v;
			ref_latched = s.ref_v[15] ? 10'd1000 : 10'((rv * 1000) / 65535);
		end else begin
			if (filter_on) begin
				a = push_average(AVG_AMP, s.amp);
				p = push_average(AVG_PWR, s.power);
			end else begin
				push_median(MED_AMP, s.amp);
				push_median(MED_PWR, s.power);
				a = window_median(MED_AMP);
				p = window_median(MED_PWR);
			end
			r.run         = 1'b1;
			r.amp_level   = 10'((a * 1000) / 65535);
			r.power_level = 11'((p * 1333) / 65535);
			r.memory_bar  = bar_step(window_median(MED_MEM));
			f = window_median(MED_FREQ);
			r.actual_bar  = bar_step(f);
			c = center_hz;
			w = swing_hz;
			h = c + w - (f * w * 2) / 65535;
			if (h < 0)
				h = 0;
			if (h > 65535)
				h = 65535;
			if (filter_on)
				h = push_average(AVG_FREQ, 16'(h));
			r.frequency_hz = 16'(h);
		end
		r.ext_amp         = 16'(xa);
		r.ext_freq_offset = 16'(xf);
		r.ten_volt_ref    = ref_latched;
		return r;
	endfunction

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h8000;
			3: return 16'h7FFF;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic write_reg(logic [2:0] index, logic [15:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		set_reg(index, value);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic offer_scan(scan_t s, logic powered, logic typed, level_t typed_level);
		int     gap_pct;
		level_t predicted;
		gap_pct = (flow == FLOW_SENDER_IDLE) ? 72 : (flow == FLOW_BOTH_IDLE) ? 38 : 0;
		@(negedge clk);
		while ($urandom_range(0, 99) < gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= powered;
		s_axis_tdata  <= {s.ref_v, s.ext_amp, s.ext_freq, s.memory, s.power, s.amp, s.freq};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predicted = condition_scan(s, powered);
		due_levels.push_back(typed ? typed_level : predicted);
	endtask

	// drop the request and wait for the pipeline to empty
	task automatic settle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (due_levels.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic compare_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (hold_served != hold_asked) begin
			hold_served = hold_asked;
			hold_left   = HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else begin
			case (flow)
				FLOW_RECEIVER_STALL: m_axis_tready <= ($urandom_range(0, 99) >= 72);
				FLOW_BOTH_IDLE: m_axis_tready <= ($urandom_range(0, 99) >= 38);
				default: m_axis_tready <= 1'b1;
			endcase
		end
	end

	always @(posedge clk) begin : check_levels
		level_t want;
		level_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tuser, m_axis_tdata};
			if (due_levels.size() == 0) begin
				$display("%0t: result with none expected, actual %h", $time, got);
				mismatches++;
			end else begin
				want = due_levels.pop_front();
				compare_field("run_valid", want.run, got.run);
				compare_field("amp_level", want.amp_level, got.amp_level);
				compare_field("power_level", want.power_level, got.power_level);
				compare_field("memory_bar", want.memory_bar, got.memory_bar);
				compare_field("actual_bar", want.actual_bar, got.actual_bar);
				compare_field("frequency_hz", want.frequency_hz, got.frequency_hz);
				compare_field("ext_amp", want.ext_amp, got.ext_amp);
				compare_field("ext_freq_offset", want.ext_freq_offset, got.ext_freq_offset);
				compare_field("ten_volt_ref", want.ten_volt_ref, got.ten_volt_ref);
				compare_field("pad", want.spare, got.spare);
			end
		end
	end

	initial begin : stimulus
		level_t      typed_level;
		scan_t       s;
		logic        powered;
		logic [15:0] center;
		logic [11:0] swing;
		clear_model();
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < $size(PLAN); i++) begin
			if (PLAN[i].kind == ROW_WRITE) begin
				settle();
				write_reg(PLAN[i].reg_index, PLAN[i].reg_value);
			end else begin
				typed_level                 = '0;
				typed_level.ext_amp         = PLAN[i].want_ext_amp;
				typed_level.ext_freq_offset = PLAN[i].want_ext_freq;
				typed_level.ten_volt_ref    = PLAN[i].want_ref;
				offer_scan(PLAN[i].scan, PLAN[i].powered, PLAN[i].typed, typed_level);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			settle();
			flow = flow_t'(p % 4);
			case (p)
				0: begin center = 16'h0000; swing = 12'd4095; end
				1: begin center = 16'hFFFF; swing = 12'd4095; end
				2: begin center = 16'h0000; swing = 12'd0; end
				default: begin
					center = 16'($urandom_range(0, 65535));
					swing  = 12'($urandom_range(0, 4095));
				end
			endcase
			// upper data bits are random to exercise the register masks
			write_reg(REG_DIGITAL_FILTER, {15'($urandom), 1'((p >> 1) & 1)});
			write_reg(REG_EXT_AMP_INT, {15'($urandom), p % 3 == 1});
			write_reg(REG_EXT_FREQ_INT, {15'($urandom), p % 3 == 2});
			write_reg(REG_CENTER_FREQ, center);
			write_reg(REG_FREQ_SWING, {4'($urandom), swing});
			write_reg(3'($urandom_range(REG_FIRST_SPARE, REG_LAST_SPARE)), 16'($urandom));

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// long receiver hold while the sender keeps offering
				if (n == 20 && p % 4 == 0)
					hold_asked++;
				s.freq     = pick_sample();
				s.amp      = pick_sample();
				s.power    = pick_sample();
				s.memory   = pick_sample();
				s.ext_freq = pick_sample();
				s.ext_amp  = pick_sample();
				s.ref_v    = pick_sample();
				powered    = ($urandom_range(0, 9) != 0);
				offer_scan(s, powered, 1'b0, '0);
			end
		end

		settle();
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : watchdog
		#(2_000_000);
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

/* supply_adc_conditioner.f */
rtl/sac_pkg.sv
rtl/sac_median_window.sv
rtl/sac_moving_avg.sv
rtl/supply_adc_conditioner.sv
rtl/sac_checker.sv
test/testbench.sv
